FILE: hdl/rgtr_pkg.sv
// Shared types, constants and helpers of the range-gate theory row builder.
`timescale 1ns / 1ps
package rgtr_pkg;

    localparam int NGATES_DEF = 16;
    localparam int MAX_DELAY  = 4096;
    localparam int DL_AW      = $clog2(MAX_DELAY);
    localparam int LIM_W      = 12;
    localparam int CNT_W      = 12;
    localparam int SUM_W      = 32;
    localparam int SAMP_W     = 16;
    localparam int SP_W       = 13;

    localparam logic [0:0] CFG_BACKGROUND_ON = 1'b0;
    localparam logic [0:0] CFG_REMOTE_RX     = 1'b1;

    localparam logic [0:0] MODE_LOAD   = 1'b0;
    localparam logic [0:0] MODE_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EMIT,
        ST_READ,
        ST_ACC
    } t_state;

    // One delay-line entry.
    typedef struct packed {
        logic                     valid;
        logic signed [SAMP_W-1:0] im;
        logic signed [SAMP_W-1:0] re;
    } t_amb;

    // Control from the sequencer to the accumulator unit.
    typedef struct packed {
        logic clear;
        logic update;
    } t_acc_ctl;

    function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W+1:0] v);
        logic signed [SUM_W+1:0] hi;
        logic signed [SUM_W+1:0] lo;
        begin
            hi = (SUM_W+2)'({1'b0, {(SUM_W-1){1'b1}}});
            lo = -hi - (SUM_W+2)'(1);
            if (v > hi) begin
                sat_sum = hi[SUM_W-1:0];
            end else if (v < lo) begin
                sat_sum = lo[SUM_W-1:0];
            end else begin
                sat_sum = v[SUM_W-1:0];
            end
        end
    endfunction

endpackage

FILE: hdl/rgtr_dline.sv
// Ambiguity delay-line memory: one write port and two registered read ports.
`timescale 1ns / 1ps
module rgtr_dline (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [rgtr_pkg::DL_AW-1:0] i_waddr,
    input  rgtr_pkg::t_amb           i_wdata,
    input  logic [rgtr_pkg::DL_AW-1:0] i_raddr_a,
    input  logic [rgtr_pkg::DL_AW-1:0] i_raddr_s,
    output rgtr_pkg::t_amb           o_rdata_a,
    output rgtr_pkg::t_amb           o_rdata_s
);

    rgtr_pkg::t_amb r_mem [rgtr_pkg::MAX_DELAY];
    rgtr_pkg::t_amb r_rd_a;
    rgtr_pkg::t_amb r_rd_s;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_a <= r_mem[i_raddr_a];
        r_rd_s <= r_mem[i_raddr_s];
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_s = r_rd_s;

endmodule

FILE: hdl/rgtr_gate_acc.sv
// Per-gate window sums and counts with one shared saturating update unit.
`timescale 1ns / 1ps
module rgtr_gate_acc #(
    parameter int NGATES = rgtr_pkg::NGATES_DEF,
    parameter int GW     = $clog2(NGATES + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rgtr_pkg::t_acc_ctl                  i_ctl,
    input  logic [GW-1:0]                       i_gate,
    input  rgtr_pkg::t_amb                      i_add,
    input  rgtr_pkg::t_amb                      i_sub,
    output logic signed [rgtr_pkg::SUM_W-1:0]   o_sum_re,
    output logic signed [rgtr_pkg::SUM_W-1:0]   o_sum_im,
    output logic [rgtr_pkg::CNT_W-1:0]          o_count
);

    localparam int SW = (NGATES > 1) ? $clog2(NGATES) : 1;
    localparam int SUM_W = rgtr_pkg::SUM_W;
    localparam int CNT_W = rgtr_pkg::CNT_W;

    logic signed [SUM_W-1:0] r_sum_re [NGATES];
    logic signed [SUM_W-1:0] r_sum_im [NGATES];
    logic [CNT_W-1:0]        r_count  [NGATES];

    logic [SW-1:0]           w_idx;
    logic signed [SUM_W+1:0] w_re;
    logic signed [SUM_W+1:0] w_im;
    logic signed [CNT_W+1:0] w_cnt;
    logic signed [SUM_W-1:0] n_re;
    logic signed [SUM_W-1:0] n_im;
    logic [CNT_W-1:0]        n_cnt;

    assign w_idx = i_gate[SW-1:0];

    always_comb begin
        w_re  = (SUM_W+2)'(r_sum_re[w_idx]) + (SUM_W+2)'(i_add.re) - (SUM_W+2)'(i_sub.re);
        w_im  = (SUM_W+2)'(r_sum_im[w_idx]) + (SUM_W+2)'(i_add.im) - (SUM_W+2)'(i_sub.im);
        w_cnt = $signed({2'b00, r_count[w_idx]}) + $signed((CNT_W+2)'(i_add.valid))
                - $signed((CNT_W+2)'(i_sub.valid));
        n_re  = rgtr_pkg::sat_sum(w_re);
        n_im  = rgtr_pkg::sat_sum(w_im);
        if (w_cnt < 0) begin
            n_cnt = '0;
        end else if (w_cnt > $signed({2'b00, {CNT_W{1'b1}}})) begin
            n_cnt = '1;
        end else begin
            n_cnt = w_cnt[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            for (int g = 0; g < NGATES; g++) begin
                r_sum_re[g] <= '0;
                r_sum_im[g] <= '0;
                r_count[g]  <= '0;
            end
        end else if (i_ctl.update) begin
            r_sum_re[w_idx] <= n_re;
            r_sum_im[w_idx] <= n_im;
            r_count[w_idx]  <= n_cnt;
        end
    end

    assign o_sum_re = r_sum_re[w_idx];
    assign o_sum_im = r_sum_im[w_idx];
    assign o_count  = r_count[w_idx];

endmodule

FILE: hdl/range_gate_theory_row_builder.sv
// Top level of the range-gate theory row builder: sequencer, limits and counters.
//
//  channel  dir  handshake                 payload
//  s_axis   in   i_s_axis_tvalid/o_tready  tdata: sample or limit, tuser: mode
//  m_axis   out  o_m_axis_tvalid/i_tready  tdata: row entry, tlast: final entry
//  cfg      in   i_cfg_we                  i_cfg_addr, i_cfg_wdata
//
// A sample is accepted, followed by NGATES+1 row beats when a row is emitted, then
// each gate passes the shared accumulator (dual-read delay line) in a read and an
// accumulate state; no new sample is taken until the last gate is done.
// After reset and after each limit load with an index up to NGATES, a clearing pass
// writes all MAX_DELAY delay-line entries, one a cycle, while no input beat is taken.
// Row beats stall on i_m_axis_tready; configuration writes are taken at any time.
`timescale 1ns / 1ps
module range_gate_theory_row_builder #(
    parameter int NGATES = rgtr_pkg::NGATES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // limit_index, limit_value, amb_re, amb_im, amb_valid, prod_re, prod_im,
    // prod_valid, variance, zero fill
    input  logic [151:0] i_s_axis_tdata,
    // mode
    input  logic [0:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // gate_index, row_re, row_im, row_count, meas_re, meas_im, meas_var, zero fill
    output logic [183:0] o_m_axis_tdata,
    output logic         o_m_axis_tlast,
    input  logic         i_cfg_we,
    input  logic [0:0]   i_cfg_addr,
    input  logic [0:0]   i_cfg_wdata
);

    localparam int GW    = $clog2(NGATES + 1);
    localparam int AW    = rgtr_pkg::DL_AW;
    localparam int LIM_W = rgtr_pkg::LIM_W;
    localparam int SP_W  = rgtr_pkg::SP_W;

    rgtr_pkg::t_state r_state;
    rgtr_pkg::t_state n_state;

    logic [LIM_W-1:0] r_lims [NGATES+1];
    logic             r_bg_on;
    logic             r_remote;
    logic [AW-1:0]    r_clr_addr;
    logic [AW-1:0]    r_wr_pos;
    logic [31:0]      r_samp_idx;
    logic [SP_W-1:0]  r_since;
    logic [GW-1:0]    r_g;
    logic             r_amb_v;
    logic [31:0]      r_meas_re;
    logic [31:0]      r_meas_im;
    logic [31:0]      r_meas_var;

    // Input fields.
    logic [5:0]        w_lim_idx;
    logic [LIM_W-1:0]  w_lim_val;
    logic [15:0]       w_amb_re;
    logic [15:0]       w_amb_im;
    logic              w_amb_v;
    logic [31:0]       w_prod_re;
    logic [31:0]       w_prod_im;
    logic              w_prod_v;
    logic [31:0]       w_var;

    assign w_lim_idx = i_s_axis_tdata[5:0];
    assign w_lim_val = i_s_axis_tdata[17:6];
    assign w_amb_re  = i_s_axis_tdata[33:18];
    assign w_amb_im  = i_s_axis_tdata[49:34];
    assign w_amb_v   = i_s_axis_tdata[50];
    assign w_prod_re = i_s_axis_tdata[82:51];
    assign w_prod_im = i_s_axis_tdata[114:83];
    assign w_prod_v  = i_s_axis_tdata[115];
    assign w_var     = i_s_axis_tdata[147:116];

    logic w_acc_in;
    logic w_load;
    logic w_load_ok;
    logic w_sample;
    logic w_emit;
    logic w_last_gate;
    logic w_last_beat;
    logic w_clr_done;

    assign w_acc_in  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_load    = w_acc_in && (i_s_axis_tuser == rgtr_pkg::MODE_LOAD);
    assign w_load_ok = w_load && (w_lim_idx <= 6'(NGATES));
    assign w_sample  = w_acc_in && (i_s_axis_tuser == rgtr_pkg::MODE_SAMPLE);

    logic [LIM_W-1:0] w_top;
    logic             w_lo_ok;

    assign w_top   = r_lims[NGATES];
    // Lower pulse-distance bound is the first limit minus two, unless disabled.
    assign w_lo_ok = r_remote ||
                     ($signed({1'b0, r_since}) > ($signed({2'b00, r_lims[0]}) - 14'sd2));
    assign w_emit  = w_prod_v && (r_samp_idx >= 32'(w_top)) && w_lo_ok &&
                     (r_since <= SP_W'(w_top));

    assign w_last_gate = (r_g == GW'(NGATES - 1));
    assign w_last_beat = (r_g == GW'(NGATES));
    assign w_clr_done  = (r_clr_addr == AW'(rgtr_pkg::MAX_DELAY - 1));

    // Delay line.
    logic           w_dl_we;
    logic [AW-1:0]  w_dl_waddr;
    rgtr_pkg::t_amb w_dl_wdata;
    logic [AW-1:0]  w_raddr_a;
    logic [AW-1:0]  w_raddr_s;
    rgtr_pkg::t_amb w_rd_a;
    rgtr_pkg::t_amb w_rd_s;
    logic [AW-1:0]  w_wr_next;

    assign w_wr_next = r_wr_pos + AW'(1);

    always_comb begin
        w_dl_we    = 1'b0;
        w_dl_waddr = r_clr_addr;
        w_dl_wdata = '0;
        if (r_state == rgtr_pkg::ST_CLEAR) begin
            w_dl_we = 1'b1;
        end else if (w_sample) begin
            w_dl_we          = 1'b1;
            w_dl_waddr       = w_wr_next;
            w_dl_wdata.valid = w_amb_v;
            w_dl_wdata.re    = w_amb_v ? $signed(w_amb_re) : '0;
            w_dl_wdata.im    = w_amb_v ? $signed(w_amb_im) : '0;
        end
    end

    // A limit of L addresses delay L-1, wrapping modulo the line length.
    assign w_raddr_a = r_wr_pos - AW'(r_lims[r_g]) + AW'(1);
    assign w_raddr_s = r_wr_pos - AW'(r_lims[r_g + GW'(1)]) + AW'(1);

    rgtr_dline u_dline (
        .i_clk     (i_clk),
        .i_we      (w_dl_we),
        .i_waddr   (w_dl_waddr),
        .i_wdata   (w_dl_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_s (w_raddr_s),
        .o_rdata_a (w_rd_a),
        .o_rdata_s (w_rd_s)
    );

    rgtr_pkg::t_acc_ctl      w_acc_ctl;
    logic signed [31:0]      w_sum_re;
    logic signed [31:0]      w_sum_im;
    logic [rgtr_pkg::CNT_W-1:0] w_count;

    rgtr_gate_acc #(
        .NGATES (NGATES),
        .GW     (GW)
    ) u_acc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_acc_ctl),
        .i_gate   (r_g),
        .i_add    (w_rd_a),
        .i_sub    (w_rd_s),
        .o_sum_re (w_sum_re),
        .o_sum_im (w_sum_im),
        .o_count  (w_count)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rgtr_pkg::ST_CLEAR: begin
                if (w_clr_done) n_state = rgtr_pkg::ST_IDLE;
            end
            rgtr_pkg::ST_IDLE: begin
                if (w_load_ok) begin
                    n_state = rgtr_pkg::ST_CLEAR;
                end else if (w_sample) begin
                    n_state = w_emit ? rgtr_pkg::ST_EMIT : rgtr_pkg::ST_READ;
                end
            end
            rgtr_pkg::ST_EMIT: begin
                if (i_m_axis_tready && w_last_beat) n_state = rgtr_pkg::ST_READ;
            end
            rgtr_pkg::ST_READ: begin
                n_state = rgtr_pkg::ST_ACC;
            end
            rgtr_pkg::ST_ACC: begin
                n_state = w_last_gate ? rgtr_pkg::ST_IDLE : rgtr_pkg::ST_READ;
            end
            default: n_state = rgtr_pkg::ST_CLEAR;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        o_s_axis_tready  = 1'b0;
        o_m_axis_tvalid  = 1'b0;
        w_acc_ctl.clear  = 1'b0;
        w_acc_ctl.update = 1'b0;
        unique case (r_state)
            rgtr_pkg::ST_CLEAR: ;
            rgtr_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                w_acc_ctl.clear = w_load_ok;
            end
            rgtr_pkg::ST_EMIT:  o_m_axis_tvalid = 1'b1;
            rgtr_pkg::ST_READ:  ;
            rgtr_pkg::ST_ACC:   w_acc_ctl.update = 1'b1;
            default: ;
        endcase
    end

    // Row beat.
    logic [31:0]               w_row_re;
    logic [31:0]               w_row_im;
    logic [rgtr_pkg::CNT_W-1:0] w_row_cnt;

    always_comb begin
        w_row_re  = '0;
        w_row_im  = '0;
        w_row_cnt = '0;
        if (w_last_beat) begin
            if (r_bg_on) begin
                w_row_re  = 32'd32768;
                w_row_cnt = rgtr_pkg::CNT_W'(1);
            end
        end else begin
            w_row_cnt = w_count;
            if (w_count != '0) begin
                w_row_re = w_sum_re;
                w_row_im = w_sum_im;
            end
        end
    end

    assign o_m_axis_tdata = {6'b0, r_meas_var, r_meas_im, r_meas_re, w_row_cnt,
                             w_row_im, w_row_re, 6'(r_g)};
    assign o_m_axis_tlast = w_last_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= rgtr_pkg::ST_CLEAR;
            r_bg_on    <= 1'b0;
            r_remote   <= 1'b0;
            r_clr_addr <= '0;
            r_wr_pos   <= '0;
            r_samp_idx <= '0;
            r_since    <= SP_W'(1);
            r_g        <= '0;
            r_amb_v    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_addr == rgtr_pkg::CFG_BACKGROUND_ON) r_bg_on  <= i_cfg_wdata[0];
                if (i_cfg_addr == rgtr_pkg::CFG_REMOTE_RX)     r_remote <= i_cfg_wdata[0];
            end
            if (r_state == rgtr_pkg::ST_CLEAR) begin
                r_clr_addr <= w_clr_done ? '0 : r_clr_addr + AW'(1);
            end
            if (w_load_ok) begin
                r_wr_pos   <= '0;
                r_samp_idx <= '0;
                r_since    <= (w_lim_idx == 6'(NGATES)) ? SP_W'(w_lim_val) + SP_W'(1)
                                                        : SP_W'(w_top) + SP_W'(1);
            end
            if (w_sample) begin
                r_wr_pos <= w_wr_next;
                r_amb_v  <= w_amb_v;
                r_g      <= '0;
            end
            if (r_state == rgtr_pkg::ST_EMIT && i_m_axis_tready) begin
                r_g <= w_last_beat ? '0 : r_g + GW'(1);
            end
            if (r_state == rgtr_pkg::ST_ACC) begin
                r_g <= r_g + GW'(1);
                if (w_last_gate) begin
                    r_g <= '0;
                    if (r_amb_v) begin
                        r_since <= '0;
                    end else if (r_since != '1) begin
                        r_since <= r_since + SP_W'(1);
                    end
                    if (r_samp_idx != '1) r_samp_idx <= r_samp_idx + 32'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_ok) begin
            r_lims[w_lim_idx[GW-1:0]] <= w_lim_val;
        end
        if (w_sample) begin
            r_meas_re  <= w_prod_re;
            r_meas_im  <= w_prod_im;
            r_meas_var <= w_var;
        end
    end

endmodule

FILE: dv/range_gate_theory_row_builder_tb.sv
// Self-checking testbench of the range-gate theory row builder with a row predictor.
`timescale 1ns / 1ps
module range_gate_theory_row_builder_tb;

    localparam int NG        = rgtr_pkg::NGATES_DEF;
    localparam int MAX_DELAY = rgtr_pkg::MAX_DELAY;
    localparam int LIM_W     = rgtr_pkg::LIM_W;
    localparam int CNT_W     = rgtr_pkg::CNT_W;
    localparam int IDLE_WAIT = 40;
    localparam int WD_LIMIT  = 20000;

    typedef struct {
        logic [0:0]         mode;
        logic [5:0]         lim_idx;
        logic [LIM_W-1:0]   lim_val;
        logic signed [15:0] amb_re;
        logic signed [15:0] amb_im;
        logic               amb_vld;
        logic signed [31:0] prod_re;
        logic signed [31:0] prod_im;
        logic               prod_vld;
        logic [31:0]        prod_var;
    } t_in_beat;

    typedef struct {
        logic [5:0]         gate;
        logic signed [31:0] row_re;
        logic signed [31:0] row_im;
        logic [CNT_W-1:0]   row_cnt;
        logic signed [31:0] meas_re;
        logic signed [31:0] meas_im;
        logic [31:0]        meas_var;
        logic               last;
    } t_row_beat;

    class row_scoreboard;
        t_row_beat   pending_rows[$];
        int          n_errors;
        rgtr_pkg::t_amb delay_line[MAX_DELAY];
        int unsigned wpos;
        logic [LIM_W-1:0] limits[NG+1];
        logic signed [31:0] acc_re[NG];
        logic signed [31:0] acc_im[NG];
        int          acc_cnt[NG];
        int unsigned n_samples;
        int unsigned pulse_age;
        bit          bg_on;
        bit          remote;

        function void clear_path();
            foreach (delay_line[i]) delay_line[i] = '0;
            for (int g = 0; g < NG; g++) begin
                acc_re[g] = 0;
                acc_im[g] = 0;
                acc_cnt[g] = 0;
            end
            wpos = 0;
            n_samples = 0;
            pulse_age = limits[NG] + 1;
        endfunction

        function new();
            n_errors = 0;
            bg_on = 0;
            remote = 0;
            foreach (limits[i]) limits[i] = '0;
            clear_path();
        endfunction

        function rgtr_pkg::t_amb tap(logic [LIM_W-1:0] lim);
            int unsigned d;
            d = (int'(lim) + MAX_DELAY - 1) % MAX_DELAY;
            return delay_line[(wpos + MAX_DELAY - d) % MAX_DELAY];
        endfunction

        function logic signed [31:0] clip32(longint v);
            if (v > 64'sd2147483647) return 32'sh7fffffff;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return v[31:0];
        endfunction

        function void note_input(t_in_beat b);
            int   lo, top;
            rgtr_pkg::t_amb a, s, e;
            int   c;
            t_row_beat r;
            if (b.mode == rgtr_pkg::MODE_LOAD) begin
                if (b.lim_idx <= NG) begin
                    limits[b.lim_idx] = b.lim_val;
                    clear_path();
                end
                return;
            end
            top = limits[NG];
            lo = remote ? -1 : int'(limits[0]) - 2;
            if (b.prod_vld && n_samples >= top && int'(pulse_age) > lo
                    && int'(pulse_age) < top + 1) begin
                for (int g = 0; g <= NG; g++) begin
                    r.gate = 6'(g);
                    r.row_re = 0;
                    r.row_im = 0;
                    r.row_cnt = 0;
                    if (g < NG) begin
                        r.row_cnt = CNT_W'(acc_cnt[g]);
                        if (acc_cnt[g] != 0) begin
                            r.row_re = acc_re[g];
                            r.row_im = acc_im[g];
                        end
                    end else if (bg_on) begin
                        r.row_re = 32768;
                        r.row_cnt = 1;
                    end
                    r.meas_re = b.prod_re;
                    r.meas_im = b.prod_im;
                    r.meas_var = b.prod_var;
                    r.last = (g == NG);
                    pending_rows.push_back(r);
                end
            end
            // Invalid ambiguity samples enter the delay line as zero.
            e.valid = b.amb_vld;
            e.re = b.amb_vld ? b.amb_re : '0;
            e.im = b.amb_vld ? b.amb_im : '0;
            wpos = (wpos + 1) % MAX_DELAY;
            delay_line[wpos] = e;
            for (int g = 0; g < NG; g++) begin
                a = tap(limits[g]);
                s = tap(limits[g+1]);
                acc_re[g] = clip32(longint'(acc_re[g]) + a.re - s.re);
                acc_im[g] = clip32(longint'(acc_im[g]) + a.im - s.im);
                c = acc_cnt[g] + a.valid - s.valid;
                acc_cnt[g] = c < 0 ? 0 : (c > 4095 ? 4095 : c);
            end
            if (b.amb_vld) pulse_age = 0;
            else if (pulse_age < 8191) pulse_age++;
            if (n_samples != 32'hffffffff) n_samples++;
        endfunction

        function void check_result(t_row_beat got);
            t_row_beat x;
            if (pending_rows.size() == 0) begin
                $error("unexpected row beat, gate_index %0d", got.gate);
                n_errors++;
                return;
            end
            x = pending_rows.pop_front();
            if (got.gate !== x.gate) begin
                $error("gate_index exp %0d got %0d", x.gate, got.gate); n_errors++;
            end
            if (got.row_re !== x.row_re) begin
                $error("row_re exp %0d got %0d", x.row_re, got.row_re); n_errors++;
            end
            if (got.row_im !== x.row_im) begin
                $error("row_im exp %0d got %0d", x.row_im, got.row_im); n_errors++;
            end
            if (got.row_cnt !== x.row_cnt) begin
                $error("row_count exp %0d got %0d", x.row_cnt, got.row_cnt); n_errors++;
            end
            if (got.meas_re !== x.meas_re) begin
                $error("meas_re exp %0d got %0d", x.meas_re, got.meas_re); n_errors++;
            end
            if (got.meas_im !== x.meas_im) begin
                $error("meas_im exp %0d got %0d", x.meas_im, got.meas_im); n_errors++;
            end
            if (got.meas_var !== x.meas_var) begin
                $error("meas_var exp %0d got %0d", x.meas_var, got.meas_var); n_errors++;
            end
            if (got.last !== x.last) begin
                $error("last exp %0d got %0d", x.last, got.last); n_errors++;
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [151:0] i_s_axis_tdata;
    logic [0:0]   i_s_axis_tuser;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [183:0] o_m_axis_tdata;
    logic         o_m_axis_tlast;
    logic         i_cfg_we;
    logic [0:0]   i_cfg_addr;
    logic [0:0]   i_cfg_wdata;

    range_gate_theory_row_builder u_dut (.*);

    row_scoreboard rows = new();
    t_in_beat      cur_beat;
    int            gap_pct   = 0;
    int            stall_pct = 0;
    int            quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = '0;
        i_m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_wdata = '0;
        cur_beat = '{default: '0};
    end

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Row beat monitor and watchdog.
    always @(posedge i_clk) begin
        t_row_beat got;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.gate     = o_m_axis_tdata[5:0];
                got.row_re   = o_m_axis_tdata[37:6];
                got.row_im   = o_m_axis_tdata[69:38];
                got.row_cnt  = o_m_axis_tdata[81:70];
                got.meas_re  = o_m_axis_tdata[113:82];
                got.meas_im  = o_m_axis_tdata[145:114];
                got.meas_var = o_m_axis_tdata[177:146];
                got.last     = o_m_axis_tlast;
                rows.check_result(got);
            end
            if (i_s_axis_tvalid && o_s_axis_tready) rows.note_input(cur_beat);
            if ((o_m_axis_tvalid && i_m_axis_tready) || (i_s_axis_tvalid && o_s_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WD_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic send_beat(t_in_beat b);
        if ($urandom_range(99) < gap_pct) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        cur_beat <= b;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= b.mode;
        i_s_axis_tdata <= {4'd0, b.prod_var, b.prod_vld, b.prod_im, b.prod_re, b.amb_vld,
                           b.amb_im, b.amb_re, b.lim_val, b.lim_idx};
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic load_limit(int idx, int val);
        t_in_beat b;
        b = '{default: '0};
        b.mode = rgtr_pkg::MODE_LOAD;
        b.lim_idx = 6'(idx);
        b.lim_val = LIM_W'(val);
        send_beat(b);
    endtask

    task automatic send_sample(bit av, int are, int aim, bit pv);
        t_in_beat b;
        b.mode = rgtr_pkg::MODE_SAMPLE;
        b.lim_idx = 6'($urandom);
        b.lim_val = LIM_W'($urandom);
        b.amb_vld = av;
        b.amb_re = 16'(are);
        b.amb_im = 16'(aim);
        b.prod_vld = pv;
        b.prod_re = $urandom;
        b.prod_im = $urandom;
        b.prod_var = $urandom;
        send_beat(b);
    endtask

    // Sender goes quiet until every expected row beat has arrived.
    task automatic drain();
        @(posedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (rows.pending_rows.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] addr, bit val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (addr == rgtr_pkg::CFG_BACKGROUND_ON) rows.bg_on = val;
        else rows.remote = val;
    endtask

    // kind 0: tight ascending, 1: wide ascending, 2: unordered with a zero limit.
    task automatic load_limit_set(int kind);
        load_limit($urandom_range(NG + 1, 63), $urandom);
        load_limit(NG, $urandom_range(1, 4095));
        for (int g = 0; g <= NG; g++) begin
            case (kind)
                0: load_limit(g, 1 + g);
                1: load_limit(g, 5 + 3 * g);
                default: load_limit(g, (g == 5) ? 0 : (g == NG ? 30 : $urandom_range(1, 30)));
            endcase
        end
    endtask

    // A pulse followed by a listening window with products, plus occasional noise.
    task automatic pulse_train(int top, ref int budget);
        int span;
        repeat ($urandom_range(1, 3)) begin
            send_sample(1'b1, $urandom, $urandom, 1'($urandom_range(1)));
            budget--;
        end
        span = $urandom_range(top / 2, top + 4);
        for (int k = 0; k < span && budget > 0; k++) begin
            send_sample($urandom_range(99) < 8, $urandom, $urandom, $urandom_range(99) < 85);
            budget--;
        end
    endtask

    initial begin
        int budget;
        int tops[3];
        tops = '{NG + 1, 5 + 3 * NG, 30};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_reg(rgtr_pkg::CFG_BACKGROUND_ON, 1'b1);
        write_reg(rgtr_pkg::CFG_REMOTE_RX, 1'b0);
        load_limit_set(0);

        // Directed: extreme samples, then enough samples for rows to appear.
        send_sample(1'b1, 32767, -32768, 1'b1);
        send_sample(1'b1, -32768, 32767, 1'b0);
        send_sample(1'b0, 32767, 32767, 1'b1);
        send_sample(1'b1, -1, 0, 1'b0);
        for (int k = 0; k < 18; k++) begin
            t_in_beat b;
            b.mode = rgtr_pkg::MODE_SAMPLE;
            b.lim_idx = '1;
            b.lim_val = '1;
            b.amb_vld = (k == 9);
            b.amb_re = (k % 2) ? 16'sh7fff : 16'sh8000;
            b.amb_im = -b.amb_re;
            b.prod_vld = 1'b1;
            b.prod_re = (k % 2) ? 32'sh7fffffff : 32'sh80000000;
            b.prod_im = (k % 2) ? 32'sh80000000 : 32'sh7fffffff;
            b.prod_var = (k % 3 == 0) ? 32'hffffffff : 32'h0;
            send_beat(b);
        end
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 57; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 57; end
                default: begin gap_pct = 32; stall_pct = 32; end
            endcase
            write_reg(rgtr_pkg::CFG_BACKGROUND_ON, ph[0]);
            write_reg(rgtr_pkg::CFG_REMOTE_RX, ph[1] ^ ph[0]);
            load_limit_set(ph % 3);
            budget = 40;
            while (budget > 0) begin
                pulse_train(tops[ph % 3], budget);
                if (ph == 1 && budget < 30 && budget > 20) drain();
            end
            drain();
        end

        i_s_axis_tvalid <= 1'b0;
        drain();
        if (rows.n_errors == 0 && rows.pending_rows.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/rgtr_pkg.sv
hdl/rgtr_dline.sv
hdl/rgtr_gate_acc.sv
hdl/range_gate_theory_row_builder.sv
dv/range_gate_theory_row_builder_tb.sv
